>>> rtl/core/gcode_line_parser_core_defines.svh
// Assertion macros for the line parser checker
`ifndef GCODE_LINE_PARSER_CORE_DEFINES_SVH
`define GCODE_LINE_PARSER_CORE_DEFINES_SVH
// implication checked every clock, off in reset
`define GLP_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// implication checked in the next clock
`define GLP_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

>>> rtl/core/glp_pkg.sv
// Shared types and constants of the G-code line parser
package glp_pkg;
   typedef enum logic [3:0] {
      PH_START, PH_DROP, PH_G_FIRST, PH_G_DIG, PH_G_WS, PH_S_FIRST, PH_S_DIG,
      PH_PARAM, PH_NUM_PRE, PH_NUM_SIGN, PH_NUM_INT, PH_NUM_FRAC, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      LET_NONE, LET_X, LET_Y, LET_Z, LET_F, LET_S, LET_T
   } letter_type;

   localparam logic [47:0] ACC_CAP = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic        kind;
      logic [4:0]  present;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] f;
      logic [31:0] s;
      logic [31:0] t;
      logic [31:0] line;
   } cmd_type;
endpackage

>>> rtl/core/gcode_line_parser_core.sv
// Top level of the G-code line parser
// channel | direction | ports
// req     | in        | req_valid req_ready req_char_byte req_last_byte
// rsp     | out       | rsp_valid rsp_ready rsp_cmd_kind .. rsp_line_number
// csr     | in        | csr_valid csr_ready csr_default_feed_amount
// One byte per cycle while req_ready is high; a command leaves the front in the cycle
// of its line end, then passes a two-entry queue and an output register.
// Synchronous reset clears parser state, queue and default amount (100).
// req_ready drops whenever the queue is full, also for bytes that end no command.
module gcode_line_parser_core import glp_pkg::*; #(
   parameter int MAX_LINE = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_cmd_kind,
   output logic [4:0]  rsp_present_mask,
   output logic signed [31:0] rsp_x_pos,
   output logic signed [31:0] rsp_y_pos,
   output logic signed [31:0] rsp_z_pos,
   output logic signed [31:0] rsp_feed_rate,
   output logic [31:0] rsp_solder_amount,
   output logic signed [31:0] rsp_dwell_time,
   output logic [31:0] rsp_line_number,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_default_feed_amount
);
   logic [31:0] dflt_ff;
   logic        f_valid, f_ready, q_valid, q_ready;
   cmd_type     f_data, q_data, o_data;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) dflt_ff <= 32'd100;
      else if (csr_valid) dflt_ff <= csr_default_feed_amount;
   end

   glp_front #(.MAX_LINE(MAX_LINE)) u_front (
      .clock, .reset, .default_feed(dflt_ff), .in_valid(req_valid), .in_ready(req_ready),
      .in_char(req_char_byte), .in_last(req_last_byte),
      .cmd_valid(f_valid), .cmd_data(f_data), .cmd_ready(f_ready));
   glp_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data));
   glp_back u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(o_data));

   assign rsp_cmd_kind      = o_data.kind;
   assign rsp_present_mask  = o_data.present;
   assign rsp_x_pos         = o_data.x;
   assign rsp_y_pos         = o_data.y;
   assign rsp_z_pos         = o_data.z;
   assign rsp_feed_rate     = o_data.f;
   assign rsp_solder_amount = o_data.s;
   assign rsp_dwell_time    = o_data.t;
   assign rsp_line_number   = o_data.line;
endmodule

>>> rtl/core/glp_front.sv
// Front end: byte classifier, line state machine and number accumulator
module glp_front import glp_pkg::*; #(
   parameter int MAX_LINE = 255,
   parameter int LW = $clog2(MAX_LINE + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] default_feed,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_char,
   input  logic        in_last,
   output logic        cmd_valid,
   output cmd_type     cmd_data,
   input  logic        cmd_ready
);
   phase_type   ph_ff, ph_in;
   logic [LW-1:0] len_ff, len_in;
   logic        cr_ff, cr_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        kind_ff, kind_in;
   logic [5:0]  pres_ff, pres_in;
   logic [31:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, f_ff, f_in, s_ff, s_in, t_ff, t_in;
   logic [47:0] acc_ff, acc_in;
   logic [32:0] ipart_ff, ipart_in;
   logic        neg_ff, neg_in;
   logic [1:0]  fd_ff, fd_in;
   letter_type  let_ff, let_in;
   logic        dig_ff, dig_in;
   logic        emit;
   cmd_type     cmd;

   assign in_ready = cmd_ready;

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12;
   endfunction
   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic logic [7:0] up(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction
   function automatic logic [47:0] sat(input logic [51:0] v);
      return (v > {4'd0, ACC_CAP}) ? ACC_CAP : v[47:0];
   endfunction
   // integer part, held at 2^32 once it no longer fits 32 bits
   function automatic logic [32:0] isat(input logic [35:0] v);
      return (v >= 36'h1_0000_0000) ? 33'h1_0000_0000 : v[32:0];
   endfunction

   always_comb begin
      logic [7:0]  c, u;
      logic [3:0]  dv;
      logic [31:0] v;
      logic        fin, endl, ok, sv, commit, par, late;
      logic [47:0] feedv, cacc;
      logic        cneg;
      letter_type  clet;
      logic [32:0] cip;
      c = in_char; u = up(c); dv = c[3:0] - 4'd0;
      ph_in = ph_ff; len_in = len_ff; cr_in = cr_ff; cnt_in = cnt_ff;
      kind_in = kind_ff; pres_in = pres_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; f_in = f_ff; s_in = s_ff; t_in = t_ff;
      acc_in = acc_ff; neg_in = neg_ff; fd_in = fd_ff; let_in = let_ff; dig_in = dig_ff;
      ipart_in = ipart_ff;
      emit = 1'b0; fin = 1'b0; endl = 1'b0; commit = 1'b0; par = 1'b0; sv = 1'b0;
      late = 1'b0; feedv = '0; v = '0; ok = 1'b0;
      cacc = '0; cneg = 1'b0; clet = LET_NONE; cip = '0;
      if (in_valid && in_ready) begin
         cr_in = 1'b0;
         if (cr_ff && c == 8'd10) begin
         end else if (c == 8'd10 || c == 8'd13) begin
            cr_in = (c == 8'd13) && !in_last;
            fin = 1'b1; endl = 1'b1;
         end else begin
            if (c == 8'd0) fin = 1'b1;
            else begin
               unique case (ph_ff)
                  PH_START:
                     if (!is_blank(c)) begin
                        if (u == "G") begin dig_in = 1'b0; ph_in = PH_G_FIRST; end
                        else if (u == "S") begin kind_in = 1'b1; ph_in = PH_S_FIRST; end
                        else ph_in = PH_DROP;
                     end
                  PH_G_FIRST, PH_G_DIG:
                     if (is_digit(c)) begin
                        if (c != "0") dig_in = 1'b1;
                        ph_in = PH_G_DIG;
                     end else if (ph_ff == PH_G_FIRST && is_blank(c)) ph_in = PH_G_WS;
                     else if (ph_ff == PH_G_FIRST && (c == "+" || c == "-")) ph_in = PH_DROP;
                     else if (dig_ff) ph_in = PH_DROP;
                     else begin kind_in = 1'b0; par = 1'b1; end
                  PH_G_WS:
                     if (!is_blank(c)) begin
                        if (is_digit(c) || c == "+" || c == "-") ph_in = PH_DROP;
                        else begin kind_in = 1'b0; par = 1'b1; end
                     end
                  PH_S_FIRST:
                     if (is_digit(c)) begin
                        acc_in = {44'd0, dv}; ph_in = PH_S_DIG;
                     end else begin sv = 1'b1; feedv = {16'd0, default_feed}; par = 1'b1; end
                  PH_S_DIG:
                     if (is_digit(c))
                        acc_in = sat({acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0} + {48'd0, dv});
                     else begin sv = 1'b1; feedv = acc_ff; par = 1'b1; end
                  PH_PARAM: par = 1'b1;
                  PH_NUM_PRE, PH_NUM_SIGN:
                     if (ph_ff == PH_NUM_PRE && is_blank(c)) begin
                     end else if (ph_ff == PH_NUM_PRE && (c == "+" || c == "-")) begin
                        neg_in = (c == "-"); ph_in = PH_NUM_SIGN;
                     end else if (is_digit(c)) begin
                        acc_in = sat({acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0}
                                     + 52'(dv) * 52'd1000);
                        ipart_in = isat({ipart_ff, 3'd0} + {2'd0, ipart_ff, 1'b0}
                                        + {32'd0, dv});
                        dig_in = 1'b1; ph_in = PH_NUM_INT;
                     end else if (c == ".") ph_in = PH_NUM_FRAC;
                     else ph_in = PH_DONE;
                  PH_NUM_INT:
                     if (is_digit(c)) begin
                        acc_in = sat({acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0}
                                     + 52'(dv) * 52'd1000);
                        ipart_in = isat({ipart_ff, 3'd0} + {2'd0, ipart_ff, 1'b0}
                                        + {32'd0, dv});
                        dig_in = 1'b1;
                     end else if (c == ".") ph_in = PH_NUM_FRAC;
                     else begin commit = 1'b1; par = 1'b1; end
                  PH_NUM_FRAC:
                     if (is_digit(c)) begin
                        if (fd_ff != 2'd3) begin
                           case (fd_ff)
                              2'd0: acc_in = sat({4'd0, acc_ff} + 52'(dv) * 52'd100);
                              2'd1: acc_in = sat({4'd0, acc_ff} + 52'(dv) * 52'd10);
                              default: acc_in = sat({4'd0, acc_ff} + 52'(dv));
                           endcase
                           fd_in = fd_ff + 2'd1;
                        end
                        dig_in = 1'b1;
                     end else if (dig_ff) begin commit = 1'b1; par = 1'b1; end
                     else ph_in = PH_DONE;
                  default: ;
               endcase
            end
            len_in = len_ff + 1'b1;
            if (len_in >= LW'(MAX_LINE) || in_last) endl = 1'b1;
         end
      end
      if (par) begin
         ph_in = PH_PARAM;
         if (is_blank(c)) begin
         end else if ((u >= "A" && u <= "Z")) begin
            case (u)
               "X": let_in = LET_X;
               "Y": let_in = LET_Y;
               "Z": let_in = LET_Z;
               "F": let_in = LET_F;
               "S": let_in = LET_S;
               "T", "P": let_in = LET_T;
               default: let_in = LET_NONE;
            endcase
            acc_in = '0; ipart_in = '0; neg_in = 1'b0; fd_in = '0; dig_in = 1'b0;
            ph_in = PH_NUM_PRE;
         end else ph_in = PH_DONE;
      end
      // text ends at NUL or line end: close the field open after this byte
      if (fin || endl) begin
         unique case (ph_in)
            PH_START, PH_G_FIRST, PH_G_DIG, PH_G_WS: ph_in = PH_DROP;
            PH_S_FIRST: begin sv = 1'b1; feedv = {16'd0, default_feed}; ph_in = PH_DONE; end
            PH_S_DIG: begin sv = 1'b1; feedv = acc_in; ph_in = PH_DONE; end
            PH_NUM_INT: begin commit = 1'b1; late = 1'b1; ph_in = PH_DONE; end
            PH_NUM_FRAC: begin commit = dig_in; late = 1'b1; ph_in = PH_DONE; end
            PH_PARAM, PH_NUM_PRE, PH_NUM_SIGN: ph_in = PH_DONE;
            default: ;
         endcase
      end
      // a commit at NUL or line end sees this byte's number, otherwise the stored one
      cacc = late ? acc_in : acc_ff;
      cneg = late ? neg_in : neg_ff;
      clet = late ? let_in : let_ff;
      cip  = late ? ipart_in : ipart_ff;
      if (commit) begin
         if (cneg) v = (cacc >= 48'h8000_0000) ? 32'h8000_0000 : 32'd0 - cacc[31:0];
         else v = (cacc > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : cacc[31:0];
         case (clet)
            LET_X: begin x_in = v; pres_in[0] = 1'b1; end
            LET_Y: begin y_in = v; pres_in[1] = 1'b1; end
            LET_Z: begin z_in = v; pres_in[2] = 1'b1; end
            LET_F: begin f_in = v; pres_in[3] = 1'b1; end
            LET_T: begin t_in = v; pres_in[4] = 1'b1; end
            LET_S: begin sv = 1'b1; feedv = cneg ? 48'd0 : {15'd0, cip}; end
            default: ;
         endcase
      end
      if (sv) begin
         s_in = (feedv > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : feedv[31:0];
         pres_in[5] = 1'b1;
      end
      cmd.kind = kind_in; cmd.present = pres_in[4:0];
      cmd.x = x_in; cmd.y = y_in; cmd.z = z_in; cmd.f = f_in;
      cmd.s = s_in; cmd.t = t_in; cmd.line = cnt_ff + 32'd1;
      if (endl) begin
         cnt_in = cnt_ff + 32'd1;
         ok = kind_in ? (s_in != 32'd0) : (pres_in[2:0] != 3'd0);
         emit = (ph_in == PH_DONE) && ok;
         ph_in = PH_START; len_in = '0; kind_in = 1'b0; pres_in = '0;
         x_in = '0; y_in = '0; z_in = '0; f_in = '0; s_in = '0; t_in = '0;
         acc_in = '0; ipart_in = '0; neg_in = 1'b0; fd_in = '0; let_in = LET_NONE;
         dig_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_START; len_ff <= '0; cr_ff <= 1'b0; cnt_ff <= '0;
         kind_ff <= 1'b0; pres_ff <= '0; x_ff <= '0; y_ff <= '0; z_ff <= '0;
         f_ff <= '0; s_ff <= '0; t_ff <= '0; acc_ff <= '0; neg_ff <= 1'b0;
         fd_ff <= '0; let_ff <= LET_NONE; dig_ff <= 1'b0; ipart_ff <= '0;
      end else begin
         ph_ff <= ph_in; len_ff <= len_in; cr_ff <= cr_in; cnt_ff <= cnt_in;
         kind_ff <= kind_in; pres_ff <= pres_in; x_ff <= x_in; y_ff <= y_in;
         z_ff <= z_in; f_ff <= f_in; s_ff <= s_in; t_ff <= t_in; acc_ff <= acc_in;
         neg_ff <= neg_in; fd_ff <= fd_in; let_ff <= let_in; dig_ff <= dig_in;
         ipart_ff <= ipart_in;
      end
   end

   assign cmd_valid = emit;
   assign cmd_data  = cmd;
endmodule

>>> rtl/core/glp_queue.sv
// Two-entry command queue between front and back
module glp_queue import glp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  cmd_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output cmd_type rd_data
);
   cmd_type   mem_ff [2];
   logic      wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic      wr, rd;

   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = mem_ff[rp_ff];
   assign cnt_in = cnt_ff + {1'b0, wr} - {1'b0, rd};

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_in;
      end
   end
endmodule

>>> rtl/core/glp_back.sv
// Back end: output register that presents commands on the result channel
module glp_back import glp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_data
);
   logic    vld_ff;
   cmd_type dat_ff;

   assign cmd_ready = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_data  = dat_ff;

   always_ff @(posedge clock) begin
      if (cmd_ready) dat_ff <= cmd_data;
      if (reset) vld_ff <= 1'b0;
      else if (cmd_ready) vld_ff <= cmd_valid;
   end
endmodule

>>> rtl/core/glp_checker.sv
// Port-level checker for the line parser, bound to the top level
`include "gcode_line_parser_core_defines.svh"
module glp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_cmd_kind,
   input logic [4:0]  rsp_present_mask,
   input logic [31:0] rsp_solder_amount
);
   `GLP_ASSERT_IMP(a_move_has_axis, clock, reset, rsp_valid && !rsp_cmd_kind, rsp_present_mask[2:0] != 3'd0)
   `GLP_ASSERT_IMP(a_feed_nonzero, clock, reset, rsp_valid && rsp_cmd_kind, rsp_solder_amount != 32'd0)
   `GLP_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind gcode_line_parser_core glp_checker u_glp_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_cmd_kind, .rsp_present_mask,
   .rsp_solder_amount);
